FILE: hw/rtl/sfc_pkg.sv
// Shared types and constants of the shape-fill canvas engine.
// Used by sfc_shape_unit, sfc_canvas and shape_fill_canvas_engine_top.
// Depends on nothing else.
`default_nettype none

package sfc_pkg;

    localparam int MAX_ROWS   = 256;
    localparam int MAX_COLS   = 256;
    localparam int NUM_COLORS = 9;

    localparam int ACT_W   = 3;
    localparam int POS_W   = 10;
    localparam int SIZE_W  = 9;
    localparam int COLOR_W = 4;
    localparam int COUNT_W = 17;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;

    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    localparam int ROW_CMP_W = ((ROW_W > CFG_W) ? ROW_W : CFG_W) + 1;
    localparam int COL_CMP_W = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;

    localparam int MAX_XY_W = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int D_W      = ((MAX_XY_W > POS_W) ? MAX_XY_W : POS_W) + 2;
    localparam int SQ_W     = 2 * D_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
    localparam logic [CFG_W-1:0]   CFG_ROWS_RESET = 9'd256;
    localparam logic [CFG_W-1:0]   CFG_COLS_RESET = 9'd256;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_DISC    = 3'd0,
        ACT_DIAMOND = 3'd1,
        ACT_RECT    = 3'd2,
        ACT_TRI     = 3'd3,
        ACT_CLEAR   = 3'd4,
        ACT_READ    = 3'd5,
        ACT_COUNT   = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_READ,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_PX,
        MUL_PY,
        MUL_R
    } t_mul_sel;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [SIZE_W-1:0]  radius;
        logic [SIZE_W-1:0]  rect_length;
        logic [SIZE_W-1:0]  shape_width;
        logic [COLOR_W-1:0] color;
    } t_item;

    typedef struct packed {
        logic     setup;
        t_mul_sel mul_sel;
        logic     row_step;
        logic     col_step;
    } t_shape_ctl;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [COLOR_W-1:0] wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
        logic               count_clr;
        logic               count_on;
        logic [COLOR_W-1:0] count_color;
    } t_canvas_req;

endpackage

`default_nettype wire

FILE: hw/rtl/shape_fill_canvas_engine_top.sv
// Top level of the shape-fill canvas engine: command sequencer, size registers,
// result register and the instances of sfc_shape_unit and sfc_canvas.
// Depends on sfc_pkg, sfc_shape_unit and sfc_canvas.

// The engine holds a canvas of 4-bit colors and takes one command at a time on the
// input stream; every command gives exactly one result transfer. After reset the
// engine runs a clearing pass over all 65536 canvas entries, one per cycle, and keeps
// s_axis_tready low throughout that pass; configuration writes are taken throughout.
// A clear command repeats that pass. A draw takes setup steps on the shared squarer
// (the squares of pos_x, pos_y and radius), then visits every in-use cell once, one
// cell per cycle through the single canvas write port. A color count reads every
// in-use cell through the single read port. Commands that do nothing (a draw or count
// with a color above 9, an empty canvas, the unused code) skip straight to the result.
// A result may wait in the output register while the next command is accepted.
`default_nettype none

module shape_fill_canvas_engine_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tdata: action[2:0], pos_x[12:3], pos_y[22:13], radius[31:23],
    // rect_length[40:32], shape_width[49:41], color[53:50], zero[55:54]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sfc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tdata: cell_color[3:0], color_count[20:4], zero[23:21]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sfc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sfc_pkg::CFG_W-1:0]       i_cfg_data
);

    sfc_pkg::t_state             r_state, n_state;
    sfc_pkg::t_mul_sel           r_step, n_step;
    logic [sfc_pkg::ROW_W-1:0]   r_x, n_x;
    logic [sfc_pkg::COL_W-1:0]   r_y, n_y;
    sfc_pkg::t_item              r_item, n_item, s_item;
    logic                        r_clr_cmd, n_clr_cmd;
    logic                        r_hit, n_hit;
    logic [sfc_pkg::CFG_W-1:0]   r_rows_cfg, r_cols_cfg;
    logic                        r_out_valid, n_out_valid;
    logic [sfc_pkg::COLOR_W-1:0] r_out_cell, n_out_cell;
    logic [sfc_pkg::COUNT_W-1:0] r_out_count, n_out_count;

    logic [sfc_pkg::ROW_CMP_W-1:0] rows_used;
    logic [sfc_pkg::COL_CMP_W-1:0] cols_used;
    logic                          area_empty, x_last, y_last, full_x_last, full_y_last;
    logic                          s_color_ok;
    logic [sfc_pkg::D_W-1:0]       rd_px, rd_py;
    logic                          rd_hit;
    logic                          cell_in_shape;
    logic [sfc_pkg::COLOR_W-1:0]   canvas_rdata;
    logic [sfc_pkg::COUNT_W-1:0]   canvas_count;
    logic                          canvas_busy;
    sfc_pkg::t_shape_ctl           shape_ctl;
    sfc_pkg::t_canvas_req          canvas_req;

    assign s_item.action      = s_axis_tdata[2:0];
    assign s_item.pos_x       = s_axis_tdata[12:3];
    assign s_item.pos_y       = s_axis_tdata[22:13];
    assign s_item.radius      = s_axis_tdata[31:23];
    assign s_item.rect_length = s_axis_tdata[40:32];
    assign s_item.shape_width = s_axis_tdata[49:41];
    assign s_item.color       = s_axis_tdata[53:50];

    assign s_color_ok = s_item.color <= sfc_pkg::COLOR_W'(sfc_pkg::NUM_COLORS);

    assign rows_used = (sfc_pkg::ROW_CMP_W'(r_rows_cfg) > sfc_pkg::ROW_CMP_W'(sfc_pkg::MAX_ROWS))
                     ? sfc_pkg::ROW_CMP_W'(sfc_pkg::MAX_ROWS) : sfc_pkg::ROW_CMP_W'(r_rows_cfg);
    assign cols_used = (sfc_pkg::COL_CMP_W'(r_cols_cfg) > sfc_pkg::COL_CMP_W'(sfc_pkg::MAX_COLS))
                     ? sfc_pkg::COL_CMP_W'(sfc_pkg::MAX_COLS) : sfc_pkg::COL_CMP_W'(r_cols_cfg);
    assign area_empty = (rows_used == '0) || (cols_used == '0);

    assign x_last = (sfc_pkg::ROW_CMP_W'(r_x) + sfc_pkg::ROW_CMP_W'(1)) == rows_used;
    assign y_last = (sfc_pkg::COL_CMP_W'(r_y) + sfc_pkg::COL_CMP_W'(1)) == cols_used;
    assign full_x_last = &r_x;
    assign full_y_last = &r_y;

    assign rd_px  = {{(sfc_pkg::D_W-sfc_pkg::POS_W){r_item.pos_x[sfc_pkg::POS_W-1]}},
                     r_item.pos_x};
    assign rd_py  = {{(sfc_pkg::D_W-sfc_pkg::POS_W){r_item.pos_y[sfc_pkg::POS_W-1]}},
                     r_item.pos_y};
    assign rd_hit = !rd_px[sfc_pkg::D_W-1] && !rd_py[sfc_pkg::D_W-1]
                 && (rd_px < sfc_pkg::D_W'(rows_used)) && (rd_py < sfc_pkg::D_W'(cols_used));

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_x         = r_x;
        n_y         = r_y;
        n_item      = r_item;
        n_clr_cmd   = r_clr_cmd;
        n_hit       = r_hit;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_cell  = r_out_cell;
        n_out_count = r_out_count;
        shape_ctl   = '0;
        shape_ctl.mul_sel = r_step;
        canvas_req  = '0;
        canvas_req.count_color = r_item.color;
        s_axis_tready = (r_state == sfc_pkg::ST_IDLE);

        unique case (r_state)
            sfc_pkg::ST_CLEAR: begin
                canvas_req.we    = 1'b1;
                canvas_req.waddr = {r_x, r_y};
                canvas_req.wdata = '0;
                if (full_y_last) begin
                    n_y = '0;
                    if (full_x_last) begin
                        n_x     = '0;
                        n_state = r_clr_cmd ? sfc_pkg::ST_DRAIN : sfc_pkg::ST_IDLE;
                    end else begin
                        n_x = r_x + sfc_pkg::ROW_W'(1);
                    end
                end else begin
                    n_y = r_y + sfc_pkg::COL_W'(1);
                end
            end
            sfc_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_item    = s_item;
                    n_x       = '0;
                    n_y       = '0;
                    n_step    = sfc_pkg::MUL_PX;
                    n_clr_cmd = 1'b0;
                    canvas_req.count_clr = 1'b1;
                    case (s_item.action) inside
                        sfc_pkg::ACT_DISC, sfc_pkg::ACT_DIAMOND,
                        sfc_pkg::ACT_RECT, sfc_pkg::ACT_TRI: begin
                            n_state = (s_color_ok && !area_empty)
                                    ? sfc_pkg::ST_SETUP : sfc_pkg::ST_OUT;
                        end
                        sfc_pkg::ACT_CLEAR: begin
                            n_state   = sfc_pkg::ST_CLEAR;
                            n_clr_cmd = 1'b1;
                        end
                        sfc_pkg::ACT_READ: begin
                            n_state = sfc_pkg::ST_READ;
                        end
                        sfc_pkg::ACT_COUNT: begin
                            n_state = (s_color_ok && !area_empty)
                                    ? sfc_pkg::ST_SCAN : sfc_pkg::ST_OUT;
                        end
                        default: begin
                            n_state = sfc_pkg::ST_OUT;
                        end
                    endcase
                end
            end
            sfc_pkg::ST_SETUP: begin
                shape_ctl.setup = 1'b1;
                unique case (r_step)
                    sfc_pkg::MUL_PX: n_step = sfc_pkg::MUL_PY;
                    sfc_pkg::MUL_PY: n_step = sfc_pkg::MUL_R;
                    default:         n_state = sfc_pkg::ST_SCAN;
                endcase
            end
            sfc_pkg::ST_SCAN: begin
                if (r_item.action == sfc_pkg::ACT_COUNT) begin
                    canvas_req.re       = 1'b1;
                    canvas_req.count_on = 1'b1;
                    canvas_req.raddr    = {r_x, r_y};
                end else begin
                    canvas_req.we    = cell_in_shape;
                    canvas_req.waddr = {r_x, r_y};
                    canvas_req.wdata = r_item.color;
                end
                if (y_last) begin
                    n_y = '0;
                    if (x_last) begin
                        n_state = sfc_pkg::ST_DRAIN;
                    end else begin
                        n_x = r_x + sfc_pkg::ROW_W'(1);
                        shape_ctl.row_step = 1'b1;
                    end
                end else begin
                    n_y = r_y + sfc_pkg::COL_W'(1);
                    shape_ctl.col_step = 1'b1;
                end
            end
            sfc_pkg::ST_READ: begin
                n_hit            = rd_hit;
                canvas_req.re    = 1'b1;
                canvas_req.raddr = {rd_px[sfc_pkg::ROW_W-1:0], rd_py[sfc_pkg::COL_W-1:0]};
                n_state          = sfc_pkg::ST_DRAIN;
            end
            sfc_pkg::ST_DRAIN: begin
                if (!canvas_busy) begin
                    n_state = sfc_pkg::ST_OUT;
                end
            end
            sfc_pkg::ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_cell  = ((r_item.action == sfc_pkg::ACT_READ) && r_hit)
                                ? canvas_rdata : '0;
                    n_out_count = (r_item.action == sfc_pkg::ACT_COUNT) ? canvas_count : '0;
                    n_state     = sfc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sfc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfc_pkg::ST_CLEAR;
            r_step      <= sfc_pkg::MUL_PX;
            r_x         <= '0;
            r_y         <= '0;
            r_clr_cmd   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_x         <= n_x;
            r_y         <= n_y;
            r_clr_cmd   <= n_clr_cmd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_hit       <= n_hit;
        r_out_cell  <= n_out_cell;
        r_out_count <= n_out_count;
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= sfc_pkg::CFG_ROWS_RESET;
            r_cols_cfg <= sfc_pkg::CFG_COLS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sfc_pkg::REG_ROWS: r_rows_cfg <= i_cfg_data;
                sfc_pkg::REG_COLS: r_cols_cfg <= i_cfg_data;
            endcase
        end
    end

    sfc_shape_unit u_shape (
        .i_clk    (i_clk),
        .i_ctl    (shape_ctl),
        .i_item   (r_item),
        .o_inside (cell_in_shape)
    );

    sfc_canvas u_canvas (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (canvas_req),
        .o_rdata (canvas_rdata),
        .o_count (canvas_count),
        .o_busy  (canvas_busy)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(sfc_pkg::OUT_TDATA_W-sfc_pkg::COUNT_W-sfc_pkg::COLOR_W){1'b0}},
                            r_out_count, r_out_cell};

`ifndef SYNTHESIS
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input still ready in the cycle after a transfer.");

    a_write_states : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        canvas_req.we |-> (r_state == sfc_pkg::ST_CLEAR) || (r_state == sfc_pkg::ST_SCAN))
        else $error("Canvas written outside a clearing pass or a draw scan.");

    a_count_no_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfc_pkg::ST_SCAN) && (r_item.action == sfc_pkg::ACT_COUNT)
        |-> !canvas_req.we)
        else $error("Canvas written during a color count.");

    a_result_from_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == sfc_pkg::ST_OUT)
        else $error("Result raised outside the result state.");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/sfc_shape_unit.sv
// Shared shape unit: one squarer for the setup steps and incremental distance terms
// that are stepped along the canvas scan, plus the per-cell containment test.
// Depends on sfc_pkg.
`default_nettype none

module sfc_shape_unit (
    input  logic                i_clk,
    input  sfc_pkg::t_shape_ctl i_ctl,
    input  sfc_pkg::t_item      i_item,
    output logic                o_inside
);

    localparam logic signed [sfc_pkg::D_W-1:0] ONE_D = 1;

    logic signed [sfc_pkg::D_W-1:0] r_dx, r_dy, n_dx, n_dy;
    logic signed [sfc_pkg::D_W-1:0] px_ext, py_ext;
    logic [sfc_pkg::SQ_W-1:0]       r_sq_x, r_sq_y, r_py2, r_r2;
    logic [sfc_pkg::SQ_W-1:0]       n_sq_x, n_sq_y, n_py2, n_r2;
    logic [sfc_pkg::POS_W-1:0]      mag_px, mag_py, mul_a;
    logic [2*sfc_pkg::POS_W-1:0]    mul_p;
    logic [sfc_pkg::SQ_W-1:0]       mul_q;
    logic signed [sfc_pkg::D_W:0]   step_x, step_y;
    logic [sfc_pkg::D_W-1:0]        abs_dx, abs_dy;
    logic [sfc_pkg::D_W:0]          man_sum;
    logic [sfc_pkg::SQ_W:0]         sq_sum;
    logic [sfc_pkg::SIZE_W-1:0]     half_w;
    logic                           in_disc, in_diamond, in_rect, in_tri;

    assign px_ext = {{(sfc_pkg::D_W-sfc_pkg::POS_W){i_item.pos_x[sfc_pkg::POS_W-1]}},
                     i_item.pos_x};
    assign py_ext = {{(sfc_pkg::D_W-sfc_pkg::POS_W){i_item.pos_y[sfc_pkg::POS_W-1]}},
                     i_item.pos_y};

    assign mag_px = i_item.pos_x[sfc_pkg::POS_W-1] ? sfc_pkg::POS_W'(-px_ext) : i_item.pos_x;
    assign mag_py = i_item.pos_y[sfc_pkg::POS_W-1] ? sfc_pkg::POS_W'(-py_ext) : i_item.pos_y;

    always_comb begin
        unique case (i_ctl.mul_sel)
            sfc_pkg::MUL_PX: mul_a = mag_px;
            sfc_pkg::MUL_PY: mul_a = mag_py;
            sfc_pkg::MUL_R:  mul_a = sfc_pkg::POS_W'(i_item.radius);
            default:         mul_a = '0;
        endcase
    end

    assign mul_p  = mul_a * mul_a;
    assign mul_q  = sfc_pkg::SQ_W'(mul_p);
    assign step_x = {r_dx, 1'b1};
    assign step_y = {r_dy, 1'b1};

    always_comb begin
        n_dx   = r_dx;
        n_dy   = r_dy;
        n_sq_x = r_sq_x;
        n_sq_y = r_sq_y;
        n_py2  = r_py2;
        n_r2   = r_r2;
        if (i_ctl.setup) begin
            unique case (i_ctl.mul_sel)
                sfc_pkg::MUL_PX: begin
                    n_sq_x = mul_q;
                    n_dx   = -px_ext;
                    n_dy   = -py_ext;
                end
                sfc_pkg::MUL_PY: begin
                    n_sq_y = mul_q;
                    n_py2  = mul_q;
                end
                sfc_pkg::MUL_R: begin
                    n_r2 = mul_q;
                end
                default: begin
                    n_r2 = r_r2;
                end
            endcase
        end else if (i_ctl.row_step) begin
            n_dx   = r_dx + ONE_D;
            n_dy   = -py_ext;
            n_sq_x = r_sq_x + sfc_pkg::SQ_W'(step_x);
            n_sq_y = r_py2;
        end else if (i_ctl.col_step) begin
            n_dy   = r_dy + ONE_D;
            n_sq_y = r_sq_y + sfc_pkg::SQ_W'(step_y);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_sq_x <= n_sq_x;
        r_sq_y <= n_sq_y;
        r_py2  <= n_py2;
        r_r2   <= n_r2;
    end

    assign abs_dx  = r_dx[sfc_pkg::D_W-1] ? unsigned'(-r_dx) : unsigned'(r_dx);
    assign abs_dy  = r_dy[sfc_pkg::D_W-1] ? unsigned'(-r_dy) : unsigned'(r_dy);
    assign man_sum = {1'b0, abs_dx} + {1'b0, abs_dy};
    assign sq_sum  = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign half_w  = (i_item.shape_width == '0) ? '0
                   : ((i_item.shape_width - sfc_pkg::SIZE_W'(1)) >> 1);

    assign in_disc    = sq_sum <= {1'b0, r_r2};
    assign in_diamond = man_sum <= (sfc_pkg::D_W+1)'(i_item.radius);
    assign in_rect    = !r_dx[sfc_pkg::D_W-1] && !r_dy[sfc_pkg::D_W-1]
                     && (abs_dx < sfc_pkg::D_W'(i_item.rect_length))
                     && (abs_dy < sfc_pkg::D_W'(i_item.shape_width));
    assign in_tri     = !r_dy[sfc_pkg::D_W-1] && (man_sum <= (sfc_pkg::D_W+1)'(half_w));

    always_comb begin
        unique case (i_item.action)
            sfc_pkg::ACT_DISC:    o_inside = in_disc;
            sfc_pkg::ACT_DIAMOND: o_inside = in_diamond;
            sfc_pkg::ACT_RECT:    o_inside = in_rect;
            sfc_pkg::ACT_TRI:     o_inside = in_tri;
            default:              o_inside = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sfc_canvas.sv
// Canvas store: one write port and one registered read port on the color memory,
// with the saturating color counter fed by the read data.
// Depends on sfc_pkg.
`default_nettype none

module sfc_canvas (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfc_pkg::t_canvas_req        i_req,
    output logic [sfc_pkg::COLOR_W-1:0] o_rdata,
    output logic [sfc_pkg::COUNT_W-1:0] o_count,
    output logic                        o_busy
);

    logic [sfc_pkg::COLOR_W-1:0] r_mem [0:sfc_pkg::MEM_DEPTH-1];
    logic                        r_we;
    logic [sfc_pkg::ADDR_W-1:0]  r_waddr;
    logic [sfc_pkg::COLOR_W-1:0] r_wdata;
    logic                        r_rvalid;
    logic                        r_rcount;
    logic [sfc_pkg::COLOR_W-1:0] r_rdata;
    logic [sfc_pkg::COUNT_W-1:0] r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_req.count_clr) begin
            n_count = '0;
        end else if (r_rvalid && r_rcount && (r_rdata == i_req.count_color)
                     && (r_count != sfc_pkg::COUNT_MAX)) begin
            n_count = r_count + sfc_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we     <= 1'b0;
            r_rvalid <= 1'b0;
            r_rcount <= 1'b0;
            r_count  <= '0;
        end else begin
            r_we     <= i_req.we;
            r_rvalid <= i_req.re;
            r_rcount <= i_req.re & i_req.count_on;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= i_req.waddr;
        r_wdata <= i_req.wdata;
    end

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem[r_waddr] <= r_wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;
    assign o_busy  = r_we | r_rvalid;

endmodule

`default_nettype wire

FILE: tb/shape_fill_canvas_engine_top_tb.sv
// Self-checking testbench for shape_fill_canvas_engine_top: directed and random commands
// with configuration writes, each result checked against a canvas kept by the testbench.
// Depends on sfc_pkg and the engine RTL.
module shape_fill_canvas_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [sfc_pkg::ACT_W-1:0] ACT_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        logic [sfc_pkg::ACT_W-1:0]        action;
        logic signed [sfc_pkg::POS_W-1:0] pos_x;
        logic signed [sfc_pkg::POS_W-1:0] pos_y;
        logic [sfc_pkg::SIZE_W-1:0]       radius;
        logic [sfc_pkg::SIZE_W-1:0]       rect_length;
        logic [sfc_pkg::SIZE_W-1:0]       shape_width;
        logic [sfc_pkg::COLOR_W-1:0]      color;
    } t_canvas_cmd;

    typedef struct {
        logic [sfc_pkg::COLOR_W-1:0] cell_color;
        logic [sfc_pkg::COUNT_W-1:0] color_count;
    } t_canvas_result;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [sfc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [sfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            i_cfg_valid   = 1'b0;
    logic                            o_cfg_ready;
    logic [sfc_pkg::CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [sfc_pkg::CFG_W-1:0]       i_cfg_data    = '0;

    logic [sfc_pkg::COLOR_W-1:0] canvas_model [sfc_pkg::MAX_ROWS][sfc_pkg::MAX_COLS];
    logic [sfc_pkg::CFG_W-1:0]   rows_reg = sfc_pkg::CFG_ROWS_RESET;
    logic [sfc_pkg::CFG_W-1:0]   cols_reg = sfc_pkg::CFG_COLS_RESET;
    t_canvas_result              pending_results [$];

    int send_idle_pct = 33;
    int recv_idle_pct = 64;
    int mismatches    = 0;
    int results_seen  = 0;
    int draws_sent    = 0;
    int queries_sent  = 0;
    int clears_sent   = 0;
    int others_sent   = 0;
    int sizes_used    = 0;
    int clears_left   = 2;
    int quiet_cycles  = 0;

    shape_fill_canvas_engine_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void blank_canvas();
        foreach (canvas_model[x, y]) canvas_model[x][y] = '0;
    endfunction

    function automatic int mag(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit in_shape(logic [sfc_pkg::ACT_W-1:0] shape, int dx, int dy,
                                    int r, int len, int wid);
        int h;
        h = (wid > 0) ? (wid - 1) / 2 : 0;
        case (shape)
            sfc_pkg::ACT_DISC:    return dx * dx + dy * dy <= r * r;
            sfc_pkg::ACT_DIAMOND: return mag(dx) + mag(dy) <= r;
            sfc_pkg::ACT_RECT:    return dx >= 0 && dx < len && dy >= 0 && dy < wid;
            default:              return mag(dx) <= h && dy >= 0 && dy <= h - mag(dx);
        endcase
    endfunction

    function automatic t_canvas_result predict_command(t_canvas_cmd c);
        t_canvas_result res;
        int rows;
        int cols;
        int px;
        int py;
        res.cell_color  = '0;
        res.color_count = '0;
        rows = (rows_reg > sfc_pkg::MAX_ROWS) ? sfc_pkg::MAX_ROWS : int'(rows_reg);
        cols = (cols_reg > sfc_pkg::MAX_COLS) ? sfc_pkg::MAX_COLS : int'(cols_reg);
        px = c.pos_x;
        py = c.pos_y;
        if (c.action <= sfc_pkg::ACT_TRI) begin
            if (c.color <= sfc_pkg::NUM_COLORS) begin
                for (int x = 0; x < rows; x++)
                    for (int y = 0; y < cols; y++)
                        if (in_shape(c.action, x - px, y - py, int'(c.radius),
                                     int'(c.rect_length), int'(c.shape_width)))
                            canvas_model[x][y] = c.color;
            end
        end else if (c.action == sfc_pkg::ACT_CLEAR) begin
            blank_canvas();
        end else if (c.action == sfc_pkg::ACT_READ) begin
            if (px >= 0 && py >= 0 && px < rows && py < cols)
                res.cell_color = canvas_model[px][py];
        end else if (c.action == sfc_pkg::ACT_COUNT) begin
            for (int x = 0; x < rows; x++)
                for (int y = 0; y < cols; y++)
                    if (canvas_model[x][y] == c.color
                        && res.color_count != sfc_pkg::COUNT_MAX)
                        res.color_count++;
        end
        return res;
    endfunction

    function automatic t_canvas_cmd make_cmd(logic [sfc_pkg::ACT_W-1:0] action, int px,
                                             int py, int r, int len, int wid, int color);
        t_canvas_cmd c;
        c.action      = action;
        c.pos_x       = sfc_pkg::POS_W'(px);
        c.pos_y       = sfc_pkg::POS_W'(py);
        c.radius      = sfc_pkg::SIZE_W'(r);
        c.rect_length = sfc_pkg::SIZE_W'(len);
        c.shape_width = sfc_pkg::SIZE_W'(wid);
        c.color       = sfc_pkg::COLOR_W'(color);
        return c;
    endfunction

    task automatic send_cmd(t_canvas_cmd c);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, c.color, c.shape_width, c.rect_length, c.radius,
                          c.pos_y, c.pos_x, c.action};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_command(c));
        if (c.action <= sfc_pkg::ACT_TRI) draws_sent++;
        else if (c.action == sfc_pkg::ACT_CLEAR) clears_sent++;
        else if (c.action == sfc_pkg::ACT_READ || c.action == sfc_pkg::ACT_COUNT) queries_sent++;
        else others_sent++;
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [sfc_pkg::CFG_IDX_W-1:0] index, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= sfc_pkg::CFG_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == sfc_pkg::REG_ROWS) rows_reg = sfc_pkg::CFG_W'(value);
        else cols_reg = sfc_pkg::CFG_W'(value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_canvas_size(int rows, int cols);
        hold_until_drained();
        write_reg(sfc_pkg::REG_ROWS, rows);
        write_reg(sfc_pkg::REG_COLS, cols);
        sizes_used++;
    endtask

    task automatic test_full_canvas();
        send_cmd(make_cmd(sfc_pkg::ACT_READ, 0, 0, 0, 0, 1, 0));
        send_cmd(make_cmd(sfc_pkg::ACT_DISC, 128, 128, 40, 0, 1, 3));
        send_cmd(make_cmd(sfc_pkg::ACT_READ, 128, 168, 0, 0, 1, 0));
        send_cmd(make_cmd(sfc_pkg::ACT_READ, 128, 169, 0, 0, 1, 0));
        send_cmd(make_cmd(sfc_pkg::ACT_COUNT, 0, 0, 0, 0, 1, 3));
        send_cmd(make_cmd(sfc_pkg::ACT_DISC, 0, 0, 511, 0, 1, 12));
        send_cmd(make_cmd(sfc_pkg::ACT_COUNT, 0, 0, 0, 0, 1, 15));
        send_cmd(make_cmd(ACT_UNUSED, -1, -1, 511, 511, 511, 15));
    endtask

    task automatic test_small_shapes();
        set_canvas_size(12, 16);
        send_cmd(make_cmd(sfc_pkg::ACT_DIAMOND, 5, 5, 3, 0, 1, 1));
        send_cmd(make_cmd(sfc_pkg::ACT_RECT, -2, 10, 0, 4, 511, 2));
        send_cmd(make_cmd(sfc_pkg::ACT_RECT, 3, 3, 0, 0, 5, 7));
        send_cmd(make_cmd(sfc_pkg::ACT_TRI, 6, 0, 0, 0, 9, 4));
        send_cmd(make_cmd(sfc_pkg::ACT_TRI, 0, 15, 0, 0, 0, 5));
        send_cmd(make_cmd(sfc_pkg::ACT_DISC, 11, 15, 0, 0, 1, 9));
        send_cmd(make_cmd(sfc_pkg::ACT_DISC, -512, 511, 511, 0, 1, 6));
        send_cmd(make_cmd(sfc_pkg::ACT_READ, 6, 2, 0, 0, 1, 0));
        send_cmd(make_cmd(sfc_pkg::ACT_COUNT, 0, 0, 0, 0, 1, 0));
        send_cmd(make_cmd(sfc_pkg::ACT_COUNT, 0, 0, 0, 0, 1, 3));
    endtask

    task automatic test_size_extremes();
        set_canvas_size(0, 16);
        send_cmd(make_cmd(sfc_pkg::ACT_DIAMOND, 0, 0, 5, 0, 1, 8));
        send_cmd(make_cmd(sfc_pkg::ACT_COUNT, 0, 0, 0, 0, 1, 0));
        send_cmd(make_cmd(sfc_pkg::ACT_READ, 0, 0, 0, 0, 1, 0));
        set_canvas_size(511, 511);
        send_cmd(make_cmd(sfc_pkg::ACT_READ, 128, 128, 0, 0, 1, 0));
        send_cmd(make_cmd(sfc_pkg::ACT_READ, 255, 255, 0, 0, 1, 0));
        send_cmd(make_cmd(sfc_pkg::ACT_READ, 256, 10, 0, 0, 1, 0));
        set_canvas_size(1, 1);
        send_cmd(make_cmd(sfc_pkg::ACT_COUNT, 0, 0, 0, 0, 1, 0));
    endtask

    task automatic test_clear();
        send_cmd(make_cmd(sfc_pkg::ACT_CLEAR, 0, 0, 0, 0, 1, 0));
        send_cmd(make_cmd(sfc_pkg::ACT_COUNT, 0, 0, 0, 0, 1, 0));
    endtask

    task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
        t_canvas_cmd c;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % 11 == 0)
                set_canvas_size(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 20),
                                ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 20));
            c.action = sfc_pkg::ACT_W'($urandom_range(7));
            if (c.action == sfc_pkg::ACT_CLEAR) begin
                if (clears_left > 0) clears_left--;
                else c.action = sfc_pkg::ACT_COUNT;
            end
            c.pos_x = sfc_pkg::POS_W'(($urandom_range(4) == 0) ? int'($urandom)
                                      : int'($urandom_range(rows_reg + 6)) - 3);
            c.pos_y = sfc_pkg::POS_W'(($urandom_range(4) == 0) ? int'($urandom)
                                      : int'($urandom_range(cols_reg + 6)) - 3);
            c.radius      = sfc_pkg::SIZE_W'(($urandom_range(4) == 0)
                                             ? $urandom_range(511) : $urandom_range(12));
            c.rect_length = sfc_pkg::SIZE_W'(($urandom_range(4) == 0)
                                             ? $urandom_range(511) : $urandom_range(12));
            c.shape_width = sfc_pkg::SIZE_W'(($urandom_range(4) == 0)
                                             ? $urandom_range(511) : $urandom_range(12));
            c.color       = sfc_pkg::COLOR_W'(($urandom_range(6) == 0)
                                              ? $urandom_range(15) : $urandom_range(9));
            send_cmd(c);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_canvas_result got;
        t_canvas_result want;
        if (m_axis_tvalid && m_axis_tready) begin
            got.cell_color  = m_axis_tdata[sfc_pkg::COLOR_W-1:0];
            got.color_count = m_axis_tdata[sfc_pkg::COLOR_W +: sfc_pkg::COUNT_W];
            results_seen++;
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("ERROR: unexpected result transfer: cell_color %0d color_count %0d",
                             got.cell_color, got.color_count);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.cell_color !== want.cell_color
                    || got.color_count !== want.color_count) begin
                    if (mismatches < 10)
                        $display("ERROR: result %0d: expected cell_color %0d %s %0d, %s %0d %0d",
                                 results_seen, want.cell_color, "color_count",
                                 want.color_count, "got", got.cell_color, got.color_count);
                    mismatches++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        blank_canvas();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_full_canvas();
        test_small_shapes();
        test_size_extremes();
        test_clear();
        test_random_traffic(24, 33, 64);
        test_random_traffic(24, 64, 33);
        test_random_traffic(24, 0, 0);
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d draws, %0d queries, %0d clears and %0d unused commands",
                 draws_sent, queries_sent, clears_sent, others_sent);
        $display("over %0d canvas sizes; %0d results compared, %0d mismatches.",
                 sizes_used + 1, results_seen, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/sfc_pkg.sv
hw/rtl/sfc_shape_unit.sv
hw/rtl/sfc_canvas.sv
hw/rtl/shape_fill_canvas_engine_top.sv
tb/shape_fill_canvas_engine_top_tb.sv
